FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers shared by the RTL
// Each macro takes a label, clock, active-low reset, the checked terms and a
// message. Defining ASSERT_OFF turns them into empty text.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/nse16_pkg.sv
// ----------------------------------------------------------------------------
// nse16_pkg: shared constants for the normalize / sRGB encode pipeline
// Field widths, fixed-point scaling and root pipeline sizes.
// ----------------------------------------------------------------------------
package nse16_pkg;

    // stream payload widths
    localparam int SAMPLE_W    = 17;
    localparam int GAIN_W      = 32;
    localparam int PIXEL_W     = 16;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 16;

    localparam int OUT_BITS_DEF = 16;

    // normalized value, Q16 with 1.0 = 65536
    localparam int X_W    = 17;
    localparam int PROD_W = 48;
    localparam logic [X_W-1:0]    X_ONE      = 17'h10000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd32768;

    // linear segment: x * 1e7 < 31308 * 65536
    localparam logic [X_W-1:0] LIN_X_MAX =
        X_W'(((64'd31308 * 64'd65536) - 64'd1) / 64'd10000000);
    localparam int LIN_X_W   = 8;
    localparam int LIN_SLOPE = 1292;

    // power segment: cube root then two square roots
    localparam int CBRT_W   = 21;
    localparam int SQRT_W   = 31;
    localparam int CBRT_SH  = 44;
    localparam int SQRT1_SH = 40;
    localparam int SQRT2_SH = 30;
    localparam int E_FRAC   = 30;

    localparam int E5_W     = 41;
    localparam int NUM_W    = 40;
    localparam int POW_GAIN = 1055;
    localparam int POW_OFFS = 55;

endpackage

FILE: hdl/nse16_cbrt.sv
// ----------------------------------------------------------------------------
// nse16_cbrt: pipelined floor cube root
// One result bit per stage, restoring digit recurrence with 3y^2 and 3y
// carried along so each stage needs only shifts, one add chain and a compare.
// ----------------------------------------------------------------------------
module nse16_cbrt #(
    parameter int ROOT_W = nse16_pkg::CBRT_W,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [3*ROOT_W-1:0] i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int RAD_W = 3 * ROOT_W;
    localparam int REM_W = 2 * ROOT_W + 2;
    localparam int SQ_W  = 2 * ROOT_W + 2;
    localparam int TR_W  = ROOT_W + 2;
    localparam int CMP_W = 2 * ROOT_W + 5;

    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SQ_W-1:0]   r_sq3  [ROOT_W];
    logic [TR_W-1:0]   r_tr3  [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              s_vld;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [SQ_W-1:0]   s_sq3;
        logic [TR_W-1:0]   s_tr3;
        logic [RAD_W-1:0]  s_rad;
        logic [SIDE_W-1:0] s_side;
        logic [CMP_W-1:0]  n_shift;
        logic [CMP_W-1:0]  n_delta;
        logic              n_take;

        if (k == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_sq3  = '0;
            assign s_tr3  = '0;
            assign s_rad  = i_rad;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_sq3  = r_sq3[k-1];
            assign s_tr3  = r_tr3[k-1];
            assign s_rad  = r_rad[k-1];
            assign s_side = r_side[k-1];
        end

        // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
        assign n_shift = {s_rem, s_rad[RAD_W-1 -: 3]};
        assign n_delta = CMP_W'({s_sq3, 2'b00}) + CMP_W'({s_tr3, 1'b0}) + CMP_W'(1);
        assign n_take  = (n_shift >= n_delta);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= n_take ? REM_W'(n_shift - n_delta) : REM_W'(n_shift);
                r_root[k] <= {s_root[ROOT_W-2:0], n_take};
                r_sq3[k]  <= n_take ? SQ_W'({s_sq3, 2'b00}) + SQ_W'({s_tr3, 2'b00}) + SQ_W'(3)
                                    : SQ_W'({s_sq3, 2'b00});
                r_tr3[k]  <= n_take ? TR_W'({s_tr3, 1'b0}) + TR_W'(3) : TR_W'({s_tr3, 1'b0});
                r_rad[k]  <= {s_rad[RAD_W-4:0], 3'b000};
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

FILE: hdl/nse16_isqrt.sv
// ----------------------------------------------------------------------------
// nse16_isqrt: pipelined floor square root
// One result bit per stage, restoring recurrence on a two-bit digit.
// ----------------------------------------------------------------------------
module nse16_isqrt #(
    parameter int ROOT_W = nse16_pkg::SQRT_W,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [2*ROOT_W-1:0] i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int CMP_W = ROOT_W + 3;

    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              s_vld;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [RAD_W-1:0]  s_rad;
        logic [SIDE_W-1:0] s_side;
        logic [CMP_W-1:0]  n_shift;
        logic [CMP_W-1:0]  n_trial;
        logic              n_take;

        if (k == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_rad  = r_rad[k-1];
            assign s_side = r_side[k-1];
        end

        assign n_shift = {s_rem, s_rad[RAD_W-1 -: 2]};
        assign n_trial = {1'b0, s_root, 2'b01};
        assign n_take  = (n_shift >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= n_take ? REM_W'(n_shift - n_trial) : REM_W'(n_shift);
                r_root[k] <= {s_root[ROOT_W-2:0], n_take};
                r_rad[k]  <= {s_rad[RAD_W-3:0], 2'b00};
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

FILE: hdl/normalize_srgb_encode16_top.sv
// ----------------------------------------------------------------------------
// normalize_srgb_encode16_top: gain normalize and sRGB encode, one pixel per sample
// 96 register stages from input to output; one sample per cycle while the output
// skid stage is empty, since a full skid stage stalls the whole pipeline and the input.
// Depth is set by 83 root stages (cube root, two square roots) plus 13 others.
// Reset clears all valids and loads gain 0.5; there is no memory to clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module normalize_srgb_encode16_top #(
    parameter int OUT_BITS = nse16_pkg::OUT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: norm_gain, unsigned Q16.16
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nse16_pkg::GAIN_W-1:0]        i_cfg_data,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [nse16_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,  // [16:0] sample
    input  logic [0:0]                          i_s_axis_tuser,  // [0] is_null
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [nse16_pkg::TDATA_OUT_W-1:0]   o_m_axis_tdata   // [15:0] pixel
);

    localparam int X_W    = nse16_pkg::X_W;
    localparam int PROD_W = nse16_pkg::PROD_W;
    localparam int CW     = nse16_pkg::CBRT_W;
    localparam int SW     = nse16_pkg::SQRT_W;
    localparam int EF     = nse16_pkg::E_FRAC;
    localparam int E5_W   = nse16_pkg::E5_W;
    localparam int NUM_W  = nse16_pkg::NUM_W;
    localparam int SIDE_W = OUT_BITS + 1;

    localparam logic [OUT_BITS-1:0] PIX_MAX = '1;

    // linear segment: floor(M * 1292 * x / 65536 / 100)
    localparam int LMUL_W  = OUT_BITS + 11;
    localparam logic [LMUL_W-1:0] LIN_MUL =
        LMUL_W'(((64'd1 << OUT_BITS) - 64'd1) * 64'd1292);
    localparam int LPROD_W = nse16_pkg::LIN_X_W + LMUL_W;
    localparam int LQ_W    = LPROD_W - 16;
    localparam int LK_W    = LQ_W;
    localparam logic [LK_W-1:0] LIN_RECIP = LK_W'((64'd1 << LQ_W) / 64'd100);
    localparam int LR_W    = LK_W + 7;

    // power segment: floor(M * num / 2^30 / 1000)
    localparam int Q1_W = NUM_W + OUT_BITS - EF;
    localparam int QK_W = OUT_BITS + 1;
    localparam logic [QK_W-1:0] Q_RECIP = QK_W'((64'd1 << Q1_W) / 64'd1000);
    localparam logic [E5_W-1:0] POW_OFF = E5_W'(nse16_pkg::POW_OFFS) << EF;

    logic w_ce;
    logic w_pop;
    logic w_push;

    logic [nse16_pkg::GAIN_W-1:0] r_gain;

    // front stages
    logic                            r1_vld;
    logic [nse16_pkg::SAMPLE_W-1:0]  r1_sample;
    logic                            r1_null;
    logic                            r2_vld;
    logic [PROD_W-1:0]               r2_prod;
    logic                            r2_pos;
    logic                            r3_vld;
    logic [X_W-1:0]                  r3_x;
    logic                            r4_vld;
    logic [X_W-1:0]                  r4_x;
    logic                            r4_lin;
    logic [LPROD_W-1:0]              r4_lprod;
    logic                            r5_vld;
    logic [X_W-1:0]                  r5_x;
    logic                            r5_lin;
    logic [LQ_W-1:0]                 r5_lq;
    logic [LK_W-1:0]                 r5_lest;
    logic                            r6_vld;
    logic [X_W-1:0]                  r6_x;
    logic [SIDE_W-1:0]               r6_side;

    logic [PROD_W-1:0]               n2_prod;
    logic                            n2_pos;
    logic [X_W-1:0]                  n3_x;
    logic [LPROD_W-1:0]              n4_lprod;
    logic [LQ_W-1:0]                 n5_lq;
    logic [LQ_W+LK_W-1:0]            n5_lmul;
    logic [LR_W-1:0]                 n6_lrem;
    logic [LK_W-1:0]                 n6_lpix;

    // root chain
    logic              w_cb_vld;
    logic [CW-1:0]     w_cb_root;
    logic [SIDE_W-1:0] w_cb_side;
    logic              w_s1_vld;
    logic [SW-1:0]     w_s1_root;
    logic [SIDE_W-1:0] w_s1_side;
    logic              w_s2_vld;
    logic [SW-1:0]     w_s2_root;
    logic [SIDE_W-1:0] w_s2_side;

    // back stages
    logic                 rp1_vld;
    logic [SW-1:0]        rp1_e;
    logic [SW-1:0]        rp1_e2;
    logic [SIDE_W-1:0]    rp1_side;
    logic                 rp2_vld;
    logic [SW-1:0]        rp2_e;
    logic [SW-1:0]        rp2_e4;
    logic [SIDE_W-1:0]    rp2_side;
    logic                 rp3_vld;
    logic [SW-1:0]        rp3_e5;
    logic [SIDE_W-1:0]    rp3_side;
    logic                 rp4_vld;
    logic [NUM_W-1:0]     rp4_num;
    logic [SIDE_W-1:0]    rp4_side;
    logic                 rp5_vld;
    logic [Q1_W-1:0]      rp5_q1;
    logic [SIDE_W-1:0]    rp5_side;
    logic                 rp6_vld;
    logic [Q1_W-1:0]      rp6_q1;
    logic [QK_W-1:0]      rp6_qest;
    logic [SIDE_W-1:0]    rp6_side;

    logic [2*SW-1:0]      np1_sq;
    logic [2*SW-1:0]      np2_sq;
    logic [2*SW-1:0]      np3_mul;
    logic [E5_W-1:0]      np4_e5k;
    logic [NUM_W+OUT_BITS-1:0] np5_mnum;
    logic [Q1_W+QK_W-1:0] np6_qmul;
    logic [Q1_W:0]        nf_qprod;
    logic [Q1_W:0]        nf_qrem;
    logic [QK_W-1:0]      nf_q;
    logic [OUT_BITS-1:0]  nf_pow;
    logic [OUT_BITS-1:0]  nf_pix;

    // output register with skid stage
    logic                                r_out_vld;
    logic [nse16_pkg::PIXEL_W-1:0]       r_out_pix;
    logic                                r_skid_vld;
    logic [nse16_pkg::PIXEL_W-1:0]       r_skid_pix;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign w_ce            = !r_skid_vld;
    assign w_pop           = r_out_vld && i_m_axis_tready;
    assign w_push          = w_ce && rp6_vld;
    assign o_s_axis_tready = w_ce;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= nse16_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // normalize and linear segment
    // ------------------------------------------------------------------
    assign n2_prod = PROD_W'(r1_sample[15:0]) * PROD_W'(r_gain);
    assign n2_pos  = !r1_null && !r1_sample[16] && (r1_sample[15:0] != '0);

    always_comb begin
        if (!r2_pos) begin
            n3_x = '0;
        end else if (r2_prod[PROD_W-1:16] > 32'(nse16_pkg::X_ONE)) begin
            n3_x = nse16_pkg::X_ONE;
        end else begin
            n3_x = r2_prod[X_W+15:16];
        end
    end

    assign n4_lprod = LPROD_W'(r3_x[nse16_pkg::LIN_X_W-1:0]) * LPROD_W'(LIN_MUL);
    assign n5_lq    = r4_lprod[LPROD_W-1:16];
    assign n5_lmul  = (LQ_W+LK_W)'(n5_lq) * (LQ_W+LK_W)'(LIN_RECIP);
    // reciprocal estimate is low by at most one
    assign n6_lrem  = LR_W'(r5_lq) - LR_W'(r5_lest) * LR_W'(100);
    assign n6_lpix  = r5_lest + LK_W'(n6_lrem >= LR_W'(100));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (w_ce) begin
            r1_vld <= i_s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_sample <= i_s_axis_tdata[nse16_pkg::SAMPLE_W-1:0];
            r1_null   <= i_s_axis_tuser[0];
            r2_prod   <= n2_prod;
            r2_pos    <= n2_pos;
            r3_x      <= n3_x;
            r4_x      <= r3_x;
            r4_lin    <= (r3_x <= nse16_pkg::LIN_X_MAX);
            r4_lprod  <= n4_lprod;
            r5_x      <= r4_x;
            r5_lin    <= r4_lin;
            r5_lq     <= n5_lq;
            r5_lest   <= n5_lmul[LQ_W+LK_W-1:LQ_W];
            r6_x      <= r5_x;
            r6_side   <= {r5_lin, n6_lpix[OUT_BITS-1:0]};
        end
    end

    // ------------------------------------------------------------------
    // t^(1/12) through cube root and two square roots
    // ------------------------------------------------------------------
    nse16_cbrt #(
        .ROOT_W (CW),
        .SIDE_W (SIDE_W)
    ) u_cbrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r6_vld),
        .i_rad   ((3*CW)'({r6_x, {nse16_pkg::CBRT_SH{1'b0}}})),
        .i_side  (r6_side),
        .o_valid (w_cb_vld),
        .o_root  (w_cb_root),
        .o_side  (w_cb_side)
    );

    nse16_isqrt #(
        .ROOT_W (SW),
        .SIDE_W (SIDE_W)
    ) u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_cb_vld),
        .i_rad   ((2*SW)'({w_cb_root, {nse16_pkg::SQRT1_SH{1'b0}}})),
        .i_side  (w_cb_side),
        .o_valid (w_s1_vld),
        .o_root  (w_s1_root),
        .o_side  (w_s1_side)
    );

    nse16_isqrt #(
        .ROOT_W (SW),
        .SIDE_W (SIDE_W)
    ) u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_s1_vld),
        .i_rad   ((2*SW)'({w_s1_root, {nse16_pkg::SQRT2_SH{1'b0}}})),
        .i_side  (w_s1_side),
        .o_valid (w_s2_vld),
        .o_root  (w_s2_root),
        .o_side  (w_s2_side)
    );

    // ------------------------------------------------------------------
    // fifth power, offset and scale
    // ------------------------------------------------------------------
    assign np1_sq   = (2*SW)'(w_s2_root) * (2*SW)'(w_s2_root);
    assign np2_sq   = (2*SW)'(rp1_e2) * (2*SW)'(rp1_e2);
    assign np3_mul  = (2*SW)'(rp2_e4) * (2*SW)'(rp2_e);
    assign np4_e5k  = E5_W'(rp3_e5) * E5_W'(nse16_pkg::POW_GAIN);
    // M * num as a shift and subtract
    assign np5_mnum = {rp4_num, {OUT_BITS{1'b0}}} - (NUM_W+OUT_BITS)'(rp4_num);
    assign np6_qmul = (Q1_W+QK_W)'(rp5_q1) * (Q1_W+QK_W)'(Q_RECIP);

    assign nf_qprod = (Q1_W+1)'(rp6_qest) * (Q1_W+1)'(1000);
    assign nf_qrem  = (Q1_W+1)'(rp6_q1) - nf_qprod;
    assign nf_q     = rp6_qest + QK_W'(nf_qrem >= (Q1_W+1)'(1000));
    assign nf_pow   = (nf_q > QK_W'(PIX_MAX)) ? PIX_MAX : nf_q[OUT_BITS-1:0];
    assign nf_pix   = rp6_side[OUT_BITS] ? rp6_side[OUT_BITS-1:0] : nf_pow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp1_vld <= 1'b0;
            rp2_vld <= 1'b0;
            rp3_vld <= 1'b0;
            rp4_vld <= 1'b0;
            rp5_vld <= 1'b0;
            rp6_vld <= 1'b0;
        end else if (w_ce) begin
            rp1_vld <= w_s2_vld;
            rp2_vld <= rp1_vld;
            rp3_vld <= rp2_vld;
            rp4_vld <= rp3_vld;
            rp5_vld <= rp4_vld;
            rp6_vld <= rp5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            rp1_e    <= w_s2_root;
            rp1_e2   <= np1_sq[EF+SW-1:EF];
            rp1_side <= w_s2_side;
            rp2_e    <= rp1_e;
            rp2_e4   <= np2_sq[EF+SW-1:EF];
            rp2_side <= rp1_side;
            rp3_e5   <= np3_mul[EF+SW-1:EF];
            rp3_side <= rp2_side;
            // clamp a negative numerator to zero
            rp4_num  <= (np4_e5k > POW_OFF) ? NUM_W'(np4_e5k - POW_OFF) : '0;
            rp4_side <= rp3_side;
            rp5_q1   <= np5_mnum[NUM_W+OUT_BITS-1:EF];
            rp5_side <= rp4_side;
            rp6_q1   <= rp5_q1;
            rp6_qest <= np6_qmul[Q1_W+QK_W-1:Q1_W];
            rp6_side <= rp5_side;
        end
    end

    // ------------------------------------------------------------------
    // output register and skid stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_vld && !w_pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_out_pix <= r_skid_pix;
            end
        end else if (w_push) begin
            if (r_out_vld && !w_pop) begin
                r_skid_pix <= nse16_pkg::PIXEL_W'(nf_pix);
            end else begin
                r_out_pix <= nse16_pkg::PIXEL_W'(nf_pix);
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_skid_needs_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid full with output empty")
    `ASSERT_IMPLIES(a_pixel_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata <= nse16_pkg::PIXEL_W'(PIX_MAX), "pixel above full scale")
    `ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, r_skid_vld && !w_pop, r_skid_vld && $stable(rp6_vld) && $stable(r1_vld), "pipeline moved during stall")

endmodule
